>>> hw/rtl/dpq_pkg.sv
// ----------------------------------------------------------------------------
// Due-date priority queue package
// Shared types, field widths and codes for the due-date priority queue.
// ----------------------------------------------------------------------------
package dpq_pkg;

    localparam int DEFAULT_DEPTH = 16;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 6;
    localparam int LEN_W   = 8;
    localparam int TAG_W   = 16;

    localparam logic [MONTH_W-1:0] MONTH_MAX      = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MAX        = 6'd31;
    localparam logic [LEN_W-1:0]   NAME_LEN_RESET = 8'd12;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } entry_t;

endpackage

>>> hw/rtl/dpq_store.sv
// ----------------------------------------------------------------------------
// Entry store
// Single write port, single registered read port memory holding queue entries.
// ----------------------------------------------------------------------------
module dpq_store
    import dpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH,
    parameter int PW          = $clog2(QUEUE_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [PW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [PW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/dpq_date_cmp.sv
// ----------------------------------------------------------------------------
// Date comparator
// Compare unit: flags a stored date strictly later than the new date.
// ----------------------------------------------------------------------------
module dpq_date_cmp
    import dpq_pkg::*;
(
    input  logic [MONTH_W-1:0] a_month,
    input  logic [DAY_W-1:0]   a_day,
    input  logic [MONTH_W-1:0] b_month,
    input  logic [DAY_W-1:0]   b_day,
    output logic               a_after
);

    always_comb
    begin
        if (a_month != b_month)
        begin
            a_after = (a_month > b_month);
        end
        else
        begin
            a_after = (a_day > b_day);
        end
    end

endmodule

>>> hw/rtl/due_date_priority_queue.sv
// ----------------------------------------------------------------------------
// Due-date priority queue
// Bounded queue of tagged items kept in due-date order, earliest at the head.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready: command 0 enqueues an item
//   (due_month, due_day, name_length, item_tag), command 1 dequeues the
//   head. Each request gives exactly one result on out_valid/out_ready.
//   cfg_wr_en/cfg_wr_data set the longest accepted name length (reset 12).
//   Entries live in a circular memory with one write and one read port; an enqueue walks from
//   the tail towards the head, shifting later-dated entries up by one.
//   A rejected request (invalid, full, empty) goes straight to S_RESP.
//   A dequeue reads the head in S_RD and takes it in S_CMP. An enqueue
//   alternates S_RD and S_CMP, one read-then-compare step on the memory
//   port per entry moved, and writes the item once it reaches the head or
//   an entry that is not later; every result then passes S_RESP.
//   One request is in progress at a time; in_ready is high only when idle.
//   A finished result is held in the output register while out_ready is
//   low; the next request may be taken, but its result waits for the slot.
//   Reset empties the queue and restores the name length limit.
// ----------------------------------------------------------------------------
module due_date_priority_queue
    import dpq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [LEN_W-1:0]   cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [MONTH_W-1:0] due_month,
    input  logic [DAY_W-1:0]   due_day,
    input  logic [LEN_W-1:0]   name_length,
    input  logic [TAG_W-1:0]   item_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               accepted,
    output logic [1:0]         status,
    output logic [TAG_W-1:0]   out_tag,
    output logic [MONTH_W-1:0] out_month,
    output logic [DAY_W-1:0]   out_day
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW:0]   DEPTH_P = (PW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0] max_len_reg;
    logic             cmd_reg, cmd_next;
    entry_t           item_reg, item_next;

    logic             res_acc_reg, res_acc_next;
    status_t          res_st_reg, res_st_next;
    entry_t           res_entry_reg, res_entry_next;

    logic             out_valid_reg;
    logic             out_acc_reg;
    status_t          out_st_reg;
    entry_t           out_entry_reg;

    logic             wr_en;
    logic [PW-1:0]    wr_addr;
    entry_t           wr_data;
    logic             rd_en;
    logic [PW-1:0]    rd_addr;
    entry_t           rd_data;
    logic             stored_after;

    logic [PW:0]      wr_sum;
    logic [PW:0]      rd_sum;
    logic [PW-1:0]    wr_phys;
    logic [PW-1:0]    rd_phys;
    logic [PW-1:0]    pos_dec;
    logic             item_ok;
    logic             in_xfer;
    logic             out_free;

    dpq_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PW          (PW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dpq_date_cmp u_cmp (
        .a_month (rd_data.month),
        .a_day   (rd_data.day),
        .b_month (item_reg.month),
        .b_day   (item_reg.day),
        .a_after (stored_after)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign item_ok = (due_month <= MONTH_MAX) && (due_day <= DAY_MAX) &&
                     (name_length != '0) && (name_length <= max_len_reg);

    // logical slot to memory address, wrapping once past the end
    assign pos_dec = pos_reg - PW'(1);
    assign wr_sum  = {1'b0, head_reg} + {1'b0, pos_reg};
    assign rd_sum  = {1'b0, head_reg} + {1'b0, pos_dec};
    assign wr_phys = (wr_sum >= DEPTH_P) ? PW'(wr_sum - DEPTH_P) : wr_sum[PW-1:0];
    assign rd_phys = (rd_sum >= DEPTH_P) ? PW'(rd_sum - DEPTH_P) : rd_sum[PW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        pos_next       = pos_reg;
        cmd_next       = cmd_reg;
        item_next      = item_reg;
        res_acc_next   = res_acc_reg;
        res_st_next    = res_st_reg;
        res_entry_next = res_entry_reg;
        wr_en          = 1'b0;
        wr_addr        = wr_phys;
        wr_data        = item_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_phys;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cmd_next       = command;
                    item_next      = '{tag: item_tag, month: due_month, day: due_day};
                    pos_next       = count_reg[PW-1:0];
                    res_acc_next   = 1'b0;
                    res_st_next    = ST_OK;
                    res_entry_next = '0;
                    if (command == CMD_ENQ)
                    begin
                        if (!item_ok)
                        begin
                            res_st_next = ST_INVALID;
                            state_next  = S_RESP;
                        end
                        else if (count_reg == DEPTH_C)
                        begin
                            res_st_next = ST_FULL;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                if (cmd_reg == CMD_DEQ)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_CMP;
                end
                else if (pos_reg == '0)
                begin
                    // insert at the head
                    wr_en        = 1'b1;
                    count_next   = count_reg + CW'(1);
                    res_acc_next = 1'b1;
                    state_next   = S_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cmd_reg == CMD_DEQ)
                begin
                    res_acc_next   = 1'b1;
                    res_entry_next = rd_data;
                    head_next      = (head_reg == LAST_P) ? '0 : head_reg + PW'(1);
                    count_next     = count_reg - CW'(1);
                    state_next     = S_RESP;
                end
                else if (stored_after)
                begin
                    // shift the later entry up one slot
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    pos_next   = pos_dec;
                    state_next = S_RD;
                end
                else
                begin
                    wr_en        = 1'b1;
                    count_next   = count_reg + CW'(1);
                    res_acc_next = 1'b1;
                    state_next   = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            max_len_reg   <= NAME_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if ((state_reg == S_RESP) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        cmd_reg       <= cmd_next;
        item_reg      <= item_next;
        res_acc_reg   <= res_acc_next;
        res_st_reg    <= res_st_next;
        res_entry_reg <= res_entry_next;
        if ((state_reg == S_RESP) && out_free)
        begin
            out_acc_reg   <= res_acc_reg;
            out_st_reg    <= res_st_reg;
            out_entry_reg <= res_entry_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = out_acc_reg;
    assign status    = out_st_reg;
    assign out_tag   = out_entry_reg.tag;
    assign out_month = out_entry_reg.month;
    assign out_day   = out_entry_reg.day;

endmodule

>>> hw/rtl/dpq_checker.sv
// ----------------------------------------------------------------------------
// Due-date priority queue checker
// Port-level assertions on the request and result channels.
// ----------------------------------------------------------------------------
module dpq_checker
    import dpq_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               accepted,
    input logic [1:0]         status,
    input logic [TAG_W-1:0]   out_tag,
    input logic [MONTH_W-1:0] out_month,
    input logic [DAY_W-1:0]   out_day
);

    // one request in flight: no transfer straight after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input transfer taken while a request is in progress");

    a_acc_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (accepted == (status == ST_OK)))
        else $error("accepted flag disagrees with status");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !accepted |-> (out_tag == '0) && (out_month == '0) && (out_day == '0))
        else $error("rejected result carries item fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_tag))
        else $error("stalled result changed");

endmodule

bind due_date_priority_queue dpq_checker u_dpq_checker (.*);

>>> verif/due_date_priority_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Due-date priority queue testbench
// Sends enqueue and dequeue requests under random input gaps and output
// stalls and predicts every result with a local sorted store and name
// length limit. Each result is checked field by field, in order. The limit
// register is rewritten between phases while the queue is idle.
// ----------------------------------------------------------------------------
module due_date_priority_queue_tb;
    import dpq_pkg::*;

    localparam int DEPTH      = DEFAULT_DEPTH;
    localparam int PHASE_REQS = 250;
    localparam int NUM_PHASES = 8;
    localparam int SETTLE     = 2 * DEPTH + 16;

    typedef struct packed {
        logic               cmd;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [LEN_W-1:0]   len;
        logic [TAG_W-1:0]   tag;
    } req_t;

    typedef struct packed {
        logic               acc;
        status_t            st;
        logic [TAG_W-1:0]   tag;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } res_t;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]   cfg_wr_data = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               command     = CMD_ENQ;
    logic [MONTH_W-1:0] due_month   = '0;
    logic [DAY_W-1:0]   due_day     = '0;
    logic [LEN_W-1:0]   name_length = '0;
    logic [TAG_W-1:0]   item_tag    = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               accepted;
    logic [1:0]         status;
    logic [TAG_W-1:0]   out_tag;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;

    req_t   request_q[$];
    res_t   result_q[$];
    entry_t due_store[$];
    logic [LEN_W-1:0] name_limit = NAME_LEN_RESET;

    int errors      = 0;
    int idle_max    = 7;
    int n_inserted  = 0;
    int n_removed   = 0;
    int n_invalid   = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int n_checked   = 0;

    due_date_priority_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .due_month   (due_month),
        .due_day     (due_day),
        .name_length (name_length),
        .item_tag    (item_tag),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .status      (status),
        .out_tag     (out_tag),
        .out_month   (out_month),
        .out_day     (out_day)
    );

    always #5 clk = ~clk;

    function automatic res_t serve_request(req_t r);
        res_t   res;
        entry_t e;
        int     pos;
        bit     item_ok;
        res = '0;
        res.st = ST_OK;
        if (r.cmd == CMD_ENQ)
        begin
            item_ok = (r.month <= MONTH_MAX) && (r.day <= DAY_MAX) &&
                      (r.len >= 1) && (r.len <= name_limit);
            if (!item_ok)
            begin
                res.st = ST_INVALID;
                n_invalid++;
            end
            else if (due_store.size() >= DEPTH)
            begin
                res.st = ST_FULL;
                n_full++;
            end
            else
            begin
                pos = 0;
                while (pos < due_store.size() &&
                       !(due_store[pos].month > r.month ||
                         (due_store[pos].month == r.month &&
                          due_store[pos].day > r.day)))
                    pos++;
                e.tag   = r.tag;
                e.month = r.month;
                e.day   = r.day;
                due_store.insert(pos, e);
                res.acc = 1'b1;
                n_inserted++;
            end
        end
        else
        begin
            if (due_store.size() == 0)
            begin
                res.st = ST_EMPTY;
                n_empty++;
            end
            else
            begin
                e = due_store.pop_front();
                res.acc   = 1'b1;
                res.tag   = e.tag;
                res.month = e.month;
                res.day   = e.day;
                n_removed++;
            end
        end
        return res;
    endfunction

    // driver
    req_t cur_req;
    int   in_wait;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                result_q.push_back(serve_request(cur_req));
            if (!in_valid || in_ready)
            begin
                if (in_wait != 0)
                begin
                    in_wait--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    cur_req = request_q.pop_front();
                    command     <= cur_req.cmd;
                    due_month   <= cur_req.month;
                    due_day     <= cur_req.day;
                    name_length <= cur_req.len;
                    item_tag    <= cur_req.tag;
                    in_valid    <= 1'b1;
                    in_wait = $urandom_range(0, idle_max);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int out_wait;

    function automatic void compare_field(string fname, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait = 0;
        end
        else if (out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tag %0d status %0d",
                         $time, out_tag, status);
                errors++;
            end
            else
            begin
                exp_r = result_q.pop_front();
                compare_field("accepted", int'(exp_r.acc), int'(accepted));
                compare_field("status", int'(exp_r.st), int'(status));
                compare_field("out_tag", int'(exp_r.tag), int'(out_tag));
                compare_field("out_month", int'(exp_r.month), int'(out_month));
                compare_field("out_day", int'(exp_r.day), int'(out_day));
                n_checked++;
            end
            out_wait = $urandom_range(0, idle_max);
            if (out_wait != 0)
                out_ready <= 1'b0;
        end
        else if (!out_ready)
        begin
            if (out_wait <= 1)
            begin
                out_wait = 0;
                out_ready <= 1'b1;
            end
            else
            begin
                out_wait--;
            end
        end
    end

    function automatic void add_req(logic c, int m, int d, int l, int t);
        req_t r;
        r.cmd   = c;
        r.month = MONTH_W'(m);
        r.day   = DAY_W'(d);
        r.len   = LEN_W'(l);
        r.tag   = TAG_W'(t);
        request_q.push_back(r);
    endfunction

    function automatic void add_random_req(int enq_pct);
        req_t r;
        int   pick;
        r.cmd   = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
        r.tag   = TAG_W'($urandom());
        r.month = MONTH_W'($urandom_range(0, MONTH_MAX));
        r.day   = DAY_W'($urandom_range(0, DAY_MAX));
        r.len   = LEN_W'((name_limit == 0) ? $urandom_range(1, 255)
                                           : $urandom_range(1, name_limit));
        if ($urandom_range(0, 99) < 30)
        begin
            // crowd dates together to force ties
            r.month = MONTH_W'($urandom_range(0, 1));
            r.day   = DAY_W'($urandom_range(0, 2));
        end
        if (r.cmd == CMD_DEQ || $urandom_range(0, 99) < 15)
        begin
            pick = $urandom_range(0, 4);
            case (pick)
                0: r.month = MONTH_W'($urandom_range(MONTH_MAX + 1, 15));
                1: r.day   = DAY_W'($urandom_range(DAY_MAX + 1, 63));
                2: r.len   = '0;
                3: r.len   = (name_limit == 8'hFF) ? '0
                                                   : LEN_W'($urandom_range(name_limit + 1, 255));
                default:
                begin
                    r.month = MONTH_W'($urandom());
                    r.day   = DAY_W'($urandom());
                    r.len   = LEN_W'($urandom());
                end
            endcase
        end
        request_q.push_back(r);
    endfunction

    task automatic wait_idle();
        while (!(request_q.size() == 0 && !in_valid && result_q.size() == 0))
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(logic [LEN_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        name_limit = v;
    endtask

    logic [LEN_W-1:0] phase_limit[NUM_PHASES];

    initial
    begin
        phase_limit[0] = 8'd255;
        phase_limit[1] = 8'd1;
        phase_limit[2] = 8'd0;
        phase_limit[3] = LEN_W'($urandom_range(2, 254));
        phase_limit[4] = NAME_LEN_RESET;
        phase_limit[5] = 8'd200;
        phase_limit[6] = LEN_W'($urandom_range(2, 254));
        phase_limit[7] = 8'd3;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty, extremes, invalid fields, ties, full
        add_req(CMD_DEQ, 0, 0, 0, 0);
        add_req(CMD_ENQ, 0, 0, 1, 16'h0000);
        add_req(CMD_ENQ, 12, 31, 12, 16'hFFFF);
        add_req(CMD_ENQ, 13, 5, 4, 16'h0101);
        add_req(CMD_ENQ, 15, 63, 255, 16'h0102);
        add_req(CMD_ENQ, 3, 32, 4, 16'h0103);
        add_req(CMD_ENQ, 3, 5, 0, 16'h0104);
        add_req(CMD_ENQ, 3, 5, 13, 16'h0105);
        add_req(CMD_ENQ, 6, 15, 5, 16'hA001);
        add_req(CMD_ENQ, 6, 15, 5, 16'hA002);
        for (int i = 0; i < DEPTH - 4; i++)
            add_req(CMD_ENQ, (i * 5) % 13, (i * 7) % 32, 1 + i % 12, 16'hB000 + i);
        add_req(CMD_ENQ, 1, 1, 1, 16'hC001);
        add_req(CMD_ENQ, 14, 1, 1, 16'hC002);
        add_req(CMD_DEQ, 0, 0, 0, 0);
        add_req(CMD_DEQ, 15, 63, 255, 16'hFFFF);
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            idle_max = (p % 3 == 2) ? 0 : 7;
            for (int i = 0; i < PHASE_REQS; i++)
                add_random_req((p % 3 == 0) ? 60 : ((p % 3 == 1) ? 45 : 75));
            wait_idle();
        end

        $display("Checked %0d results: %0d inserted, %0d removed, %0d invalid,",
                 n_checked, n_inserted, n_removed, n_invalid);
        $display("%0d rejected as full, %0d empty dequeues, over %0d limit settings",
                 n_full, n_empty, NUM_PHASES + 1);
        if (errors == 0)
            $display("due_date_priority_queue_tb: PASS");
        else
            $display("due_date_priority_queue_tb: FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding", result_q.size());
        $display("due_date_priority_queue_tb: FAIL");
        $finish;
    end

endmodule
